/* rtl/core/vsrl_pkg.sv */
// Shared types and constants for the vector slew rate limiter.
package vsrl_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned RATE_W = 31;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned MAX_PORTS = 4;
  // magnitude of a delta, and the squared-sum and norm widths
  localparam int unsigned MAG_W = 33;
  localparam int unsigned SUM_W = 68;
  localparam int unsigned NORM_W = 34;
  // limit = max_rate * step_time >> 16
  localparam int unsigned LIM_W = 47;
  // |d| * limit
  localparam int unsigned PROD_W = 80;

  localparam logic [RATE_W-1:0] RATE_RESET = 31'd65536;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED = 3'd0,
    ST_PRIMED  = 3'd1,
    ST_FOLLOW  = 3'd2,
    ST_SCALED  = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // command to the iterative unit
  typedef enum logic [2:0] {
    UOP_SQRT = 3'b001,
    UOP_DIV  = 3'b010,
    UOP_MUL  = 3'b100
  } uop_t;

  typedef struct packed {
    logic              start;
    uop_t              uop;
    logic [SUM_W-1:0]  a;
    logic [PROD_W-1:0] b;
    logic [NORM_W-1:0] c;
  } unit_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] res;
  } unit_rsp_t;

endpackage

/* rtl/core/vsrl_unit.sv */
// Shared bit-serial unit: square root, long division and shift-add multiply.
module vsrl_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vsrl_pkg::unit_req_t   req,
  output vsrl_pkg::unit_rsp_t   rsp
);

  localparam int unsigned PW = vsrl_pkg::PROD_W;
  localparam int unsigned NW = vsrl_pkg::NORM_W;
  localparam int unsigned SW = vsrl_pkg::SUM_W;

  logic              busy_r, busy_nxt;
  vsrl_pkg::uop_t    uop_r, uop_nxt;
  logic [6:0]        cnt_r, cnt_nxt;
  logic [PW-1:0]     acc_r, acc_nxt;     // root / quotient / product
  logic [PW-1:0]     src_r, src_nxt;     // radicand / dividend / multiplicand
  logic [PW+1:0]     rem_r, rem_nxt;     // partial remainder / multiplier
  logic [NW-1:0]     den_r, den_nxt;     // divisor
  logic              done_r, done_nxt;

  logic [PW+1:0] rem_sh;
  logic [PW+1:0] trial;
  logic [PW+1:0] rem_d;

  always_comb begin
    busy_nxt = busy_r;
    uop_nxt  = uop_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    src_nxt  = src_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    rem_sh   = '0;
    trial    = '0;
    rem_d    = '0;
    if (!busy_r && req.start) begin
      busy_nxt = 1'b1;
      uop_nxt  = req.uop;
      acc_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = req.c;
      unique case (req.uop)
        vsrl_pkg::UOP_SQRT: begin
          src_nxt = {{(PW-SW){1'b0}}, req.a};
          cnt_nxt = 7'(SW / 2);
        end
        vsrl_pkg::UOP_DIV: begin
          src_nxt = req.b;
          cnt_nxt = 7'(PW);
        end
        vsrl_pkg::UOP_MUL: begin
          // a holds the multiplicand, b the multiplier; c is not used
          src_nxt = {{(PW-SW){1'b0}}, req.a};
          den_nxt = '0;
          rem_nxt = {2'b00, req.b};
          cnt_nxt = 7'(vsrl_pkg::LIM_W);
        end
        default: ;
      endcase
    end else if (busy_r) begin
      unique case (uop_r)
        vsrl_pkg::UOP_SQRT: begin
          // two radicand bits a step, restoring
          rem_sh = {rem_r[PW-1:0], src_r[SW-1 -: 2]};
          trial  = {acc_r[PW-1:0], 2'b01};
          src_nxt = {src_r[PW-3:0], 2'b00};
          if (rem_sh >= trial) begin
            rem_nxt = rem_sh - trial;
            acc_nxt = {acc_r[PW-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh;
            acc_nxt = {acc_r[PW-2:0], 1'b0};
          end
        end
        vsrl_pkg::UOP_DIV: begin
          rem_sh  = {rem_r[PW:0], src_r[PW-1]};
          rem_d   = {{(PW+2-NW){1'b0}}, den_r};
          src_nxt = {src_r[PW-2:0], 1'b0};
          if (rem_sh >= rem_d) begin
            rem_nxt = rem_sh - rem_d;
            acc_nxt = {acc_r[PW-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh;
            acc_nxt = {acc_r[PW-2:0], 1'b0};
          end
        end
        vsrl_pkg::UOP_MUL: begin
          // rem holds the multiplier, shifted right one bit a step
          if (rem_r[0]) begin
            acc_nxt = acc_r + src_r;
          end
          src_nxt = {src_r[PW-2:0], 1'b0};
          rem_nxt = {1'b0, rem_r[PW+1:1]};
        end
        default: ;
      endcase
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      uop_r  <= vsrl_pkg::UOP_SQRT;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      uop_r  <= uop_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    src_r <= src_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule

/* rtl/core/vector_slew_rate_limiter.sv */
// Top level of the vector slew rate limiter: sequencer, lane store and output register.
//
//  channel | ports                                    | dir
//  --------+------------------------------------------+-----
//  input   | in_valid/in_ready, in_op, in_target_0..3, | in
//          | in_wheel_count, in_step_time              |
//  result  | out_valid/out_ready, out_0..3, out_status | out
//  config  | cfg_valid/cfg_ready, cfg_max_rate         | in
//
// A clear, ignored or priming item goes straight to the output state once accepted.
// A limited step squares and sums each lane, takes the root, forms the limit
// product, tests the norm against it and loads the output; scaling adds a product,
// a division and an update for each lane, all through the one shared bit-serial unit.
// Synchronous reset clears control state and the lane store. The input is not
// ready while an item is at work; a finished item holds in the last state until
// the output register frees, and a stalled result holds.
module vector_slew_rate_limiter #(
  parameter int unsigned LANES = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic signed [31:0]             in_target_0,
  input  logic signed [31:0]             in_target_1,
  input  logic signed [31:0]             in_target_2,
  input  logic signed [31:0]             in_target_3,
  input  logic [2:0]                     in_wheel_count,
  input  logic [31:0]                    in_step_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             out_0,
  output logic signed [31:0]             out_1,
  output logic signed [31:0]             out_2,
  output logic signed [31:0]             out_3,
  output logic [2:0]                     out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [30:0]                    cfg_max_rate
);

  localparam int unsigned LW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned NP = vsrl_pkg::MAX_PORTS;
  localparam int unsigned MW = vsrl_pkg::MAG_W;
  localparam int unsigned SW = vsrl_pkg::SUM_W;
  localparam int unsigned PW = vsrl_pkg::PROD_W;
  localparam int unsigned NW = vsrl_pkg::NORM_W;
  localparam int unsigned KW = vsrl_pkg::LIM_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SQ    = 10'b0000000010,
    S_SQW   = 10'b0000000100,
    S_ROOT  = 10'b0000001000,
    S_LIM   = 10'b0000010000,
    S_TEST  = 10'b0000100000,
    S_MUL   = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_APPLY = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [30:0]              rate_r;
  logic signed [31:0]       held_r [LANES];
  logic signed [31:0]       tgt_r [NP];
  logic                     primed_r;
  logic [31:0]              dt_r;
  logic [LW:0]              used_r;
  logic [LW-1:0]            lane_r;
  logic [SW-1:0]            sum_r;
  logic [NW-1:0]            norm_r;
  logic [KW-1:0]            lim_r;
  logic [PW-1:0]            quo_r;
  logic [2:0]               status_r;
  logic [2:0]               ostat_r;
  logic                     ovalid_r;
  logic signed [31:0]       obuf_r [NP];
  // S_ROOT/S_LIM/S_MUL/S_DIV: issue in the first cycle, wait for done
  logic                     waiting_r;

  vsrl_pkg::unit_req_t      req;
  vsrl_pkg::unit_rsp_t      rsp;

  logic signed [MW-1:0]     delta;
  logic [MW-1:0]            mag;
  logic [3:0]               cnt_eff;
  logic [LW:0]              used_in;
  logic signed [MW+1:0]     moved;
  logic signed [31:0]       moved_sat;
  logic                     last_lane;
  logic                     out_load;

  vsrl_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign delta = MW'(tgt_r[lane_r]) - MW'(held_r[lane_r]);
  assign mag   = delta[MW-1] ? -delta : delta;
  assign last_lane = ({1'b0, lane_r} == used_r - (LW+1)'(1));

  always_comb begin
    cnt_eff = {1'b0, in_wheel_count};
    if (cnt_eff > 4'(LANES)) cnt_eff = 4'(LANES);
    if (cnt_eff > 4'(NP)) cnt_eff = 4'(NP);
    used_in = (LW+1)'(cnt_eff);
  end

  // step the held value by the signed quotient, then clamp
  always_comb begin
    if (delta[MW-1]) begin
      moved = (MW+2)'(held_r[lane_r]) - $signed({1'b0, quo_r[MW:0]});
    end else begin
      moved = (MW+2)'(held_r[lane_r]) + $signed({1'b0, quo_r[MW:0]});
    end
    if (moved > (MW+2)'(32'sh7fffffff)) moved_sat = 32'sh7fffffff;
    else if (moved < -(MW+2)'(33'sh080000000)) moved_sat = 32'sh80000000;
    else moved_sat = moved[31:0];
  end

  always_comb begin
    req.start = 1'b0;
    req.uop   = vsrl_pkg::UOP_MUL;
    req.a     = '0;
    req.b     = '0;
    req.c     = norm_r;
    unique case (state_r)
      S_SQ: begin
        req.start = 1'b1;
        req.uop   = vsrl_pkg::UOP_MUL;
        req.a     = SW'(mag);
        req.b     = PW'(mag);
      end
      S_ROOT: begin
        req.start = !waiting_r;
        req.uop   = vsrl_pkg::UOP_SQRT;
        req.a     = sum_r;
      end
      S_LIM: begin
        req.start = !waiting_r;
        req.uop   = vsrl_pkg::UOP_MUL;
        req.a     = SW'(rate_r);
        req.b     = PW'(dt_r);
      end
      S_MUL: begin
        req.start = !waiting_r;
        req.uop   = vsrl_pkg::UOP_MUL;
        req.a     = SW'(mag);
        req.b     = PW'(lim_r);
      end
      S_DIV: begin
        req.start = !waiting_r;
        req.uop   = vsrl_pkg::UOP_DIV;
        req.b     = quo_r;
      end
      default: ;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_OUT) && (!ovalid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rate_r    <= vsrl_pkg::RATE_RESET;
      primed_r  <= 1'b0;
      ovalid_r  <= 1'b0;
      waiting_r <= 1'b0;
      for (int i = 0; i < LANES; i++) held_r[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) rate_r <= cfg_max_rate;
      if (out_load) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            tgt_r[0] <= in_target_0;
            tgt_r[1] <= in_target_1;
            tgt_r[2] <= in_target_2;
            tgt_r[3] <= in_target_3;
            dt_r     <= in_step_time;
            used_r   <= used_in;
            lane_r   <= '0;
            sum_r    <= '0;
            if (in_op == vsrl_pkg::OP_CLEAR) begin
              primed_r <= 1'b0;
              for (int i = 0; i < LANES; i++) held_r[i] <= '0;
              status_r <= vsrl_pkg::ST_CLEARED;
              state_r  <= S_OUT;
            end else if (used_in == '0 || in_step_time == '0) begin
              status_r <= vsrl_pkg::ST_IGNORED;
              state_r  <= S_OUT;
            end else if (!primed_r) begin
              primed_r <= 1'b1;
              for (int i = 0; i < LANES; i++) begin
                if ((LW+1)'(i) < used_in) begin
                  held_r[i] <= (i == 0) ? in_target_0 : (i == 1) ? in_target_1 :
                               (i == 2) ? in_target_2 : in_target_3;
                end
              end
              status_r <= vsrl_pkg::ST_PRIMED;
              state_r  <= S_OUT;
            end else begin
              state_r <= S_SQ;
            end
          end
        end
        S_SQ: state_r <= S_SQW;
        S_SQW: begin
          if (rsp.done) begin
            sum_r <= sum_r + SW'(rsp.res);
            if (last_lane) begin
              state_r <= S_ROOT;
            end else begin
              lane_r  <= lane_r + LW'(1);
              state_r <= S_SQ;
            end
          end
        end
        S_ROOT: begin
          if (!waiting_r) begin
            waiting_r <= 1'b1;
          end else if (rsp.done) begin
            waiting_r <= 1'b0;
            norm_r    <= rsp.res[NW-1:0];
            state_r   <= S_LIM;
          end
        end
        S_LIM: begin
          if (!waiting_r) begin
            waiting_r <= 1'b1;
          end else if (rsp.done) begin
            waiting_r <= 1'b0;
            lim_r     <= rsp.res[KW+15:16];
            state_r   <= S_TEST;
          end
        end
        S_TEST: begin
          lane_r <= '0;
          if (norm_r != '0 && 64'(norm_r) > 64'(lim_r)) begin
            status_r <= vsrl_pkg::ST_SCALED;
            state_r  <= S_MUL;
          end else begin
            for (int i = 0; i < LANES; i++) begin
              if ((LW+1)'(i) < used_r) held_r[i] <= tgt_r[i];
            end
            status_r <= vsrl_pkg::ST_FOLLOW;
            state_r  <= S_OUT;
          end
        end
        S_MUL: begin
          if (!waiting_r) begin
            waiting_r <= 1'b1;
          end else if (rsp.done) begin
            waiting_r <= 1'b0;
            quo_r     <= rsp.res;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          if (!waiting_r) begin
            waiting_r <= 1'b1;
          end else if (rsp.done) begin
            waiting_r <= 1'b0;
            quo_r     <= rsp.res;
            state_r   <= S_APPLY;
          end
        end
        S_APPLY: begin
          held_r[lane_r] <= moved_sat;
          if (last_lane) begin
            state_r <= S_OUT;
          end else begin
            lane_r  <= lane_r + LW'(1);
            state_r <= S_MUL;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            for (int i = 0; i < NP; i++) begin
              obuf_r[i] <= (i < LANES) ? held_r[(i < LANES) ? i : 0] : '0;
            end
            ostat_r <= status_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = ovalid_r;
  assign out_0      = obuf_r[0];
  assign out_1      = obuf_r[1];
  assign out_2      = obuf_r[2];
  assign out_3      = obuf_r[3];
  assign out_status = ostat_r;

endmodule

/* tb/sv/tb.sv */
// Testbench for the vector slew rate limiter: random and directed steps checked against a predictor.
module tb;

  localparam int NLANE = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = vsrl_pkg::OP_STEP;
  logic signed [31:0] in_target_0 = '0, in_target_1 = '0, in_target_2 = '0, in_target_3 = '0;
  logic [2:0] in_wheel_count = '0;
  logic [31:0] in_step_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_0, out_1, out_2, out_3;
  logic [2:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [30:0] cfg_max_rate = '0;

  vector_slew_rate_limiter #(.LANES(NLANE)) uut (.*);

  typedef struct {
    logic signed [31:0] wheel [4];
    vsrl_pkg::status_t status;
  } limited_t;

  class limit_scoreboard;
    logic [30:0] rate;
    bit primed;
    logic signed [31:0] held [4];
    limited_t pending [$];
    int errors;
    int checked;
    int n_status [5];

    function new();
      rate = vsrl_pkg::RATE_RESET;
      primed = 0;
      foreach (held[i]) held[i] = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void note_item(logic op, logic signed [31:0] t [4], logic [2:0] cnt,
                            logic [31:0] dt);
      int lanes;
      logic [67:0] sum, sq;
      logic [33:0] norm, cand;
      logic [79:0] lim, q;
      logic signed [33:0] d;
      logic [32:0] m;
      limited_t r;
      lanes = (cnt > NLANE) ? NLANE : cnt;
      if (op == vsrl_pkg::OP_CLEAR) begin
        primed = 0;
        foreach (held[i]) held[i] = '0;
        r.status = vsrl_pkg::ST_CLEARED;
      end else if (lanes == 0 || dt == 0) begin
        r.status = vsrl_pkg::ST_IGNORED;
      end else if (!primed) begin
        for (int i = 0; i < lanes; i++) held[i] = t[i];
        primed = 1;
        r.status = vsrl_pkg::ST_PRIMED;
      end else begin
        sum = '0;
        for (int i = 0; i < lanes; i++) begin
          d = 34'(t[i]) - 34'(held[i]);
          m = d < 0 ? 33'(-d) : 33'(d);
          sq = 68'(m) * 68'(m);
          sum += sq;
        end
        norm = '0;
        for (int b = 33; b >= 0; b--) begin
          cand = norm | (34'd1 << b);
          if (68'(cand) * 68'(cand) <= sum) norm = cand;
        end
        lim = (80'(rate) * 80'(dt)) >> 16;
        if (80'(norm) > lim && norm != 0) begin
          for (int i = 0; i < lanes; i++) begin
            d = 34'(t[i]) - 34'(held[i]);
            m = d < 0 ? 33'(-d) : 33'(d);
            q = (80'(m) * lim) / 80'(norm);
            held[i] = d < 0 ? held[i] - 32'(q) : held[i] + 32'(q);
          end
          r.status = vsrl_pkg::ST_SCALED;
        end else begin
          for (int i = 0; i < lanes; i++) held[i] = t[i];
          r.status = vsrl_pkg::ST_FOLLOW;
        end
      end
      foreach (held[i]) r.wheel[i] = held[i];
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] o [4], logic [2:0] st);
      limited_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.status <= vsrl_pkg::ST_CLEARED) n_status[e.status]++;
      for (int i = 0; i < 4; i++)
        if (o[i] !== e.wheel[i]) begin
          $error("out_%0d expected %0d got %0d", i, e.wheel[i], o[i]);
          errors++;
        end
      if (st !== e.status) begin
        $error("status expected %0d got %0d", e.status, st);
        errors++;
      end
    endfunction
  endclass

  limit_scoreboard sb = new();
  int send_idle = 0, recv_stall = 0;

  initial forever #1 clk = ~clk;

  initial begin
    #10000000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver with random stall
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_0, out_1, out_2, out_3}, out_status);

  // valid stays high into the next item unless the sender idles
  task automatic send_item(logic op, logic signed [31:0] t [4], logic [2:0] cnt,
                           logic [31:0] dt);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_target_0 <= t[0]; in_target_1 <= t[1]; in_target_2 <= t[2]; in_target_3 <= t[3];
    in_wheel_count <= cnt;
    in_step_time <= dt;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, t, cnt, dt);
    @(negedge clk);
  endtask

  task automatic write_rate(logic [30:0] v);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_max_rate <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.rate = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_target(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(131072)) - 65536;
      2: return 32'sh7fffffff;
      default: return 32'sh80000000;
    endcase
  endfunction

  task automatic random_item();
    logic signed [31:0] t [4];
    int mode, k;
    mode = $urandom_range(9) < 6 ? 1 : ($urandom_range(9) < 8 ? 0 : $urandom_range(3));
    foreach (t[i]) t[i] = rand_target($urandom_range(9) == 0 ? $urandom_range(3) : mode);
    k = $urandom_range(99);
    if (k < 4) send_item(vsrl_pkg::OP_CLEAR, t, 3'($urandom()), $urandom());
    else if (k < 8) send_item(vsrl_pkg::OP_STEP, t, $urandom_range(1) ? 3'd0 : 3'($urandom()),
                              $urandom_range(1) ? 32'd0 : $urandom());
    else send_item(vsrl_pkg::OP_STEP, t, 3'($urandom_range(7)),
                   $urandom_range(3) == 0 ? $urandom() : $urandom_range(1, 8192));
  endtask

  initial begin
    logic [30:0] rates [6] = '{31'd65536, 31'd0, 31'h7fffffff, 31'd1, 31'd3000000, 31'd65536};
    logic signed [31:0] mx [4] = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    logic signed [31:0] mn [4] = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000};
    logic signed [31:0] z [4] = '{0, 0, 0, 0};
    int cyc_start;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: ignored while unprimed, prime, follow, scale at extremes, clear
    send_item(vsrl_pkg::OP_STEP, mx, 3'd4, 32'd0);
    send_item(vsrl_pkg::OP_STEP, mx, 3'd0, 32'd65536);
    send_item(vsrl_pkg::OP_STEP, mx, 3'd4, 32'd65536);
    send_item(vsrl_pkg::OP_STEP, mn, 3'd7, 32'hffffffff);
    send_item(vsrl_pkg::OP_STEP, mx, 3'd4, 32'd1);
    send_item(vsrl_pkg::OP_STEP, mx, 3'd4, 32'd1);
    send_item(vsrl_pkg::OP_STEP, mn, 3'd2, 32'd65536);
    send_item(vsrl_pkg::OP_CLEAR, mx, 3'd7, 32'hffffffff);
    send_item(vsrl_pkg::OP_STEP, z, 3'd1, 32'd5);
    send_item(vsrl_pkg::OP_STEP, z, 3'd4, 32'd5);
    send_item(vsrl_pkg::OP_STEP, '{32'sd1, -32'sd1, 32'sd0, 32'sd0}, 3'd3, 32'd1);
    write_rate(31'd0);
    send_item(vsrl_pkg::OP_STEP, mn, 3'd4, 32'hffffffff);
    send_item(vsrl_pkg::OP_STEP, mx, 3'd5, 32'd2);
    write_rate(31'h7fffffff);
    send_item(vsrl_pkg::OP_STEP, mx, 3'd4, 32'hffffffff);
    send_item(vsrl_pkg::OP_STEP, mn, 3'd4, 32'd1);
    send_item(vsrl_pkg::OP_CLEAR, z, 3'd0, 32'd0);
    for (int ph = 0; ph < 6; ph++) begin
      write_rate(rates[ph]);
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 69; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 69; end
        default: begin send_idle = 26; recv_stall = 26; end
      endcase
      repeat (100) random_item();
    end
    in_valid <= 1'b0;
    send_idle = 0; recv_stall = 0;
    cyc_start = 0;
    while (sb.pending.size() != 0 && cyc_start < 100000) begin
      @(negedge clk);
      cyc_start++;
    end
    repeat (50) @(negedge clk);
    $display("Checked %0d results: %0d ignored, %0d primed, %0d followed, %0d scaled, %0d cleared",
             sb.checked, sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3],
             sb.n_status[4]);
    $display("Rates from zero to full scale, four idling phases");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
